// ===== design/dbq_pkg.sv =====
// Shared types and constants for the bounded deque with search.
package dbq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ELEM_WIDTH_DEF = 32;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_CONTAINS   = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } out_item_t;

  // per-item controls broadcast to every cell
  typedef struct packed {
    logic push_back;
    logic shift_up;
    logic shift_down;
    logic rd_en;
    logic search;
  } cell_ctrl_t;

endpackage

// ===== design/bounded_deque_with_search.sv =====
// Top level of the bounded deque with search: decode, cell chain and result register.
//
//   channel  direction  handshake           payload
//   in       input      start / busy        in_item  (op, value, index)
//   out      output     out_valid strobe    out_item (data, found, status, count)
//
// One item per cycle: the cells shift, load, read or compare in the cycle of acceptance.
// The result is registered and follows in the cycle after acceptance, on out_valid for exactly one cycle.
// busy stays low; the result register is reloaded for each accepted item.
// Synchronous active-low reset empties the list; cell contents need no clearing.
// The receiver cannot stall the result.
module bounded_deque_with_search #(
  parameter int unsigned DEPTH      = dbq_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = dbq_pkg::ELEM_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dbq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output dbq_pkg::out_item_t out_item
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > dbq_pkg::INDEX_W) ? CW : dbq_pkg::INDEX_W;

  logic                  accept;
  dbq_pkg::cell_ctrl_t   ctrl;
  logic [XW-1:0]         rd_addr;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_nxt;
  dbq_pkg::status_t      status;
  logic [ELEM_WIDTH-1:0] value;
  logic [ELEM_WIDTH-1:0] elem    [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_data [DEPTH];
  logic [DEPTH-1:0]      hit;
  logic [ELEM_WIDTH-1:0] rd_any;

  logic                  out_valid_r;
  dbq_pkg::out_item_t    out_item_r;
  dbq_pkg::out_item_t    out_item_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign value  = ELEM_WIDTH'(in_item.value);

  dbq_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .XW    (XW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_item.op),
    .index     (in_item.index),
    .ctrl      (ctrl),
    .rd_addr   (rd_addr),
    .count     (count),
    .count_nxt (count_nxt),
    .status    (status)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] lo;
    logic [ELEM_WIDTH-1:0] hi;

    if (i == 0) begin : g_head
      assign lo = value;
    end else begin : g_body
      assign lo = elem[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign hi = elem[i];
    end else begin : g_inner
      assign hi = elem[i+1];
    end

    dbq_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .CELL_IDX   (i),
      .CW         (CW),
      .XW         (XW)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .count   (count),
      .rd_addr (rd_addr),
      .value   (value),
      .from_lo (lo),
      .from_hi (hi),
      .elem    (elem[i]),
      .rd_data (rd_data[i]),
      .hit     (hit[i])
    );
  end

  // at most one cell drives its read port
  always_comb begin
    rd_any = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_any = rd_any | rd_data[k];
    end
  end

  always_comb begin
    out_item_nxt.data   = dbq_pkg::DATA_W'(rd_any);
    out_item_nxt.found  = |hit;
    out_item_nxt.status = status;
    out_item_nxt.count  = dbq_pkg::COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== design/dbq_cell.sv =====
// One storage cell of the deque chain: holds an element, shifts, matches and reads out.
module dbq_cell #(
  parameter int unsigned ELEM_WIDTH = dbq_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned CELL_IDX   = 0,
  parameter int unsigned CW         = 5,
  parameter int unsigned XW         = 5
) (
  input  logic                  clk,
  input  dbq_pkg::cell_ctrl_t   ctrl,
  input  logic [CW-1:0]         count,
  input  logic [XW-1:0]         rd_addr,
  input  logic [ELEM_WIDTH-1:0] value,
  input  logic [ELEM_WIDTH-1:0] from_lo,
  input  logic [ELEM_WIDTH-1:0] from_hi,
  output logic [ELEM_WIDTH-1:0] elem,
  output logic [ELEM_WIDTH-1:0] rd_data,
  output logic                  hit
);

  logic [ELEM_WIDTH-1:0] elem_r;
  logic [ELEM_WIDTH-1:0] elem_nxt;
  logic                  at_tail;
  logic                  held;
  logic                  rd_sel;

  assign at_tail = (count == CW'(CELL_IDX));
  assign held    = (CW'(CELL_IDX) < count);
  assign rd_sel  = ctrl.rd_en && (rd_addr == XW'(CELL_IDX));

  always_comb begin
    elem_nxt = elem_r;
    if (ctrl.shift_up) begin
      elem_nxt = from_lo;
    end else if (ctrl.shift_down) begin
      elem_nxt = from_hi;
    end else if (ctrl.push_back && at_tail) begin
      elem_nxt = value;
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign elem    = elem_r;
  assign rd_data = rd_sel ? elem_r : '0;
  assign hit     = ctrl.search && held && (elem_r == value);

endmodule

// ===== design/dbq_ctrl.sv =====
// Fill count register and operation decode for the deque chain.
module dbq_ctrl #(
  parameter int unsigned DEPTH = dbq_pkg::DEPTH_DEF,
  parameter int unsigned CW    = $clog2(DEPTH + 1),
  parameter int unsigned XW    = (CW > dbq_pkg::INDEX_W) ? CW : dbq_pkg::INDEX_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [dbq_pkg::OP_W-1:0]     op,
  input  logic [dbq_pkg::INDEX_W-1:0]  index,
  output dbq_pkg::cell_ctrl_t          ctrl,
  output logic [XW-1:0]                rd_addr,
  output logic [CW-1:0]                count,
  output logic [CW-1:0]                count_nxt,
  output dbq_pkg::status_t             status
);

  logic [CW-1:0] count_r;
  logic          full;
  logic          empty;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] cnt_x;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign idx_x = XW'(index);
  assign cnt_x = XW'(count_r);

  always_comb begin
    ctrl      = '0;
    rd_addr   = '0;
    count_nxt = count_r;
    status    = dbq_pkg::ST_OK;
    if (accept) begin
      unique case (dbq_pkg::op_t'(op))
        dbq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status = dbq_pkg::ST_FULL;
          end else begin
            ctrl.push_back = 1'b1;
            count_nxt      = count_r + 1'b1;
          end
        end
        dbq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status = dbq_pkg::ST_FULL;
          end else begin
            ctrl.shift_up = 1'b1;
            count_nxt     = count_r + 1'b1;
          end
        end
        dbq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status = dbq_pkg::ST_EMPTY;
          end else begin
            ctrl.rd_en = 1'b1;
            rd_addr    = XW'(CW'(count_r - 1'b1));
            count_nxt  = count_r - 1'b1;
          end
        end
        dbq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status = dbq_pkg::ST_EMPTY;
          end else begin
            ctrl.rd_en      = 1'b1;
            ctrl.shift_down = 1'b1;
            count_nxt       = count_r - 1'b1;
          end
        end
        dbq_pkg::OP_READ: begin
          if (idx_x >= cnt_x) begin
            status = dbq_pkg::ST_RANGE;
          end else begin
            ctrl.rd_en = 1'b1;
            rd_addr    = idx_x;
          end
        end
        dbq_pkg::OP_CONTAINS: begin
          ctrl.search = 1'b1;
        end
        dbq_pkg::OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

// ===== design/dbq_chk.sv =====
// Port-level checker for the bounded deque with search, bound to the top level.
module dbq_chk #(
  parameter int unsigned DEPTH = dbq_pkg::DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input dbq_pkg::out_item_t out_item
);

  a_result_follows: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> out_valid == $past(start && !busy))
    else $error("result strobe does not follow an accepted item by one cycle");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == dbq_pkg::ST_FULL
      |-> out_item.count == dbq_pkg::COUNT_W'(DEPTH))
    else $error("full status with a count below capacity");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == dbq_pkg::ST_EMPTY
      |-> out_item.count == '0 && out_item.data == '0)
    else $error("empty status with elements or data");

  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.found
      |-> out_item.status == dbq_pkg::ST_OK && out_item.data == '0)
    else $error("found flag with a bad status or data");

endmodule

bind bounded_deque_with_search dbq_chk #(
  .DEPTH (DEPTH)
) u_dbq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
